FILE: rtl/sfdc_pkg.sv
`timescale 1ns / 1ps

package sfdc_pkg;

  localparam int unsigned CntW      = 17;
  localparam int unsigned HdrLen    = 7;
  localparam logic [7:0]  ResvType  = 8'hff;

  localparam logic [CntW-1:0] PosUser   = CntW'(1);
  localparam logic [CntW-1:0] PosType   = CntW'(2);
  localparam logic [CntW-1:0] PosSizeLo = CntW'(3);
  localparam logic [CntW-1:0] PosSizeHi = CntW'(4);
  localparam logic [CntW-1:0] PosSeqLo  = CntW'(5);
  localparam logic [CntW-1:0] PosSeqHi  = CntW'(6);

  typedef enum logic [1:0] {
    REG_HEADER   = 2'd0,
    REG_USER_ID  = 2'd1,
    REG_MSG_TYPE = 2'd2,
    REG_CTL_TYPE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    VERDICT_OK_MSG   = 3'd0,
    VERDICT_OK_CTL   = 3'd1,
    VERDICT_BAD_SUM  = 3'd2,
    VERDICT_RESERVED = 3'd3,
    VERDICT_UNKNOWN  = 3'd4
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  user_id;
    logic [7:0]  ftype;
    logic [15:0] size;
    logic [15:0] seq;
    verdict_t    verdict;
    logic        last;
  } result_t;

endpackage

FILE: rtl/serial_frame_deframer_checksum.sv
`timescale 1ns / 1ps
// channel | ports                                   | direction
// --------+-----------------------------------------+----------
// in      | in_valid, in_stall, in_rx_byte          | request in
// out     | out_valid, out_stall, out_item_kind ... | request out
// cfg     | cfg_wr_en, cfg_index, cfg_data          | write only
//
// one byte is taken per cycle while in_stall is low; the parse, sum and counter update sit
// between the input port and the result register, or the skid register while that one is held
// a two-entry output stage (result register plus skid register) sets in_stall, which
// is registered and rises only when both entries hold a request
// rst_n is synchronous, active low; it loads the register defaults and clears the
// frame state and both output entries

module serial_frame_deframer_checksum (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_item_kind,
  output logic [7:0]            out_payload_byte,
  output logic [15:0]           out_payload_index,
  output logic [7:0]            out_frame_user_id,
  output logic [7:0]            out_frame_type,
  output logic [15:0]           out_payload_size,
  output logic [15:0]           out_sequence_id,
  output logic [2:0]            out_verdict,
  output logic                  out_last_of_frame,
  input  logic                  cfg_wr_en,
  input  sfdc_pkg::cfg_reg_t    cfg_index,
  input  logic [7:0]            cfg_data
);
  import sfdc_pkg::*;

  logic [7:0] hdr_r, uid_r, msg_type_r, ctl_type_r;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] flen_r, flen_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [7:0]      huid_r, huid_nxt;
  logic [7:0]      htype_r, htype_nxt;
  logic [15:0]     hsize_r, hsize_nxt;
  logic [15:0]     hseq_r, hseq_nxt;

  result_t main_r, skid_r, res;
  logic    main_v_r, skid_v_r;
  logic    push, pop, accept, has_res;
  logic [CntW-1:0] cnt_inc;
  logic [7:0]      sum_add;
  verdict_t        vd;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= 8'ha5;
      uid_r      <= 8'h01;
      msg_type_r <= 8'h01;
      ctl_type_r <= 8'h02;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HEADER:   hdr_r      <= cfg_data;
        REG_USER_ID:  uid_r      <= cfg_data;
        REG_MSG_TYPE: msg_type_r <= cfg_data;
        REG_CTL_TYPE: ctl_type_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept  = in_valid && !in_stall;
  assign cnt_inc = cnt_r + CntW'(1);
  assign sum_add = sum_r + in_rx_byte;

  always_comb begin
    priority if (htype_r == ResvType)   vd = VERDICT_RESERVED;
    else if (sum_add != 8'd0)           vd = VERDICT_BAD_SUM;
    else if (htype_r == msg_type_r)     vd = VERDICT_OK_MSG;
    else if (htype_r == ctl_type_r)     vd = VERDICT_OK_CTL;
    else                                vd = VERDICT_UNKNOWN;
  end

  // frame parse
  always_comb begin
    cnt_nxt   = cnt_r;
    flen_nxt  = flen_r;
    sum_nxt   = sum_r;
    huid_nxt  = huid_r;
    htype_nxt = htype_r;
    hsize_nxt = hsize_r;
    hseq_nxt  = hseq_r;
    has_res   = 1'b0;
    res.kind    = KIND_PAYLOAD;
    res.data    = in_rx_byte;
    res.index   = 16'(cnt_r - CntW'(HdrLen));
    res.user_id = huid_r;
    res.ftype   = htype_r;
    res.size    = hsize_r;
    res.seq     = hseq_r;
    res.verdict = VERDICT_OK_MSG;
    res.last    = 1'b0;
    if (accept) begin
      if (cnt_r == '0) begin
        if (in_rx_byte == hdr_r) begin
          sum_nxt = in_rx_byte;
          cnt_nxt = CntW'(1);
        end
      end else if (cnt_r == PosUser && in_rx_byte != uid_r) begin
        cnt_nxt   = '0;
        flen_nxt  = '0;
        sum_nxt   = '0;
        huid_nxt  = '0;
        htype_nxt = '0;
        hsize_nxt = '0;
        hseq_nxt  = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_inc;
        unique case (cnt_r)
          PosUser:   huid_nxt = in_rx_byte;
          PosType:   htype_nxt = in_rx_byte;
          PosSizeLo: hsize_nxt = {hsize_r[15:8], in_rx_byte};
          PosSizeHi: hsize_nxt = {in_rx_byte, hsize_r[7:0]};
          PosSeqLo:  hseq_nxt = {hseq_r[15:8], in_rx_byte};
          PosSeqHi: begin
            hseq_nxt = {in_rx_byte, hseq_r[7:0]};
            flen_nxt = {1'b0, hsize_r} + CntW'(HdrLen + 1);
          end
          default: begin
            has_res = 1'b1;
            if (flen_r != '0 && cnt_inc == flen_r) begin
              res.kind    = KIND_VERDICT;
              res.data    = 8'd0;
              res.index   = 16'd0;
              res.verdict = vd;
              res.last    = 1'b1;
              cnt_nxt   = '0;
              flen_nxt  = '0;
              sum_nxt   = '0;
              huid_nxt  = '0;
              htype_nxt = '0;
              hsize_nxt = '0;
              hseq_nxt  = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      flen_r  <= '0;
      sum_r   <= '0;
      huid_r  <= '0;
      htype_r <= '0;
      hsize_r <= '0;
      hseq_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      flen_r  <= flen_nxt;
      sum_r   <= sum_nxt;
      huid_r  <= huid_nxt;
      htype_r <= htype_nxt;
      hsize_r <= hsize_nxt;
      hseq_r  <= hseq_nxt;
    end
  end

  // output stage with skid entry
  assign push = accept && has_res;
  assign pop  = main_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign in_stall          = skid_v_r;
  assign out_valid         = main_v_r;
  assign out_item_kind     = main_r.kind;
  assign out_payload_byte  = main_r.data;
  assign out_payload_index = main_r.index;
  assign out_frame_user_id = main_r.user_id;
  assign out_frame_type    = main_r.ftype;
  assign out_payload_size  = main_r.size;
  assign out_sequence_id   = main_r.seq;
  assign out_verdict       = main_r.verdict;
  assign out_last_of_frame = main_r.last;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without result entry");

  a_cnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CntW'(HdrLen)) |-> (cnt_r < flen_r))
    else $error("byte count ran past frame length");

  a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.kind == KIND_VERDICT) |=> (cnt_r == '0 && sum_r == 8'd0))
    else $error("frame state not cleared after verdict");

  a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_kind == out_last_of_frame))
    else $error("last flag disagrees with item kind");

endmodule

FILE: tb/serial_frame_deframer_checksum_tb.sv
`timescale 1ns / 1ps

class frame_scoreboard;
  logic [7:0]  header_val, user_val, msg_code, ctl_code;
  logic [16:0] byte_pos, total_len;
  logic [7:0]  sum, held_uid, held_type;
  logic [15:0] held_size, held_seq;
  sfdc_pkg::result_t expected_q[$];
  int errors, bytes_in, payloads_out;
  int verdicts_out[5];
  string field_names[9] = '{"item_kind", "payload_byte", "payload_index", "frame_user_id",
                            "frame_type", "payload_size", "sequence_id", "verdict",
                            "last_of_frame"};

  function new();
    header_val = 8'ha5;
    user_val = 8'h01;
    msg_code = 8'h01;
    ctl_code = 8'h02;
    errors = 0;
    bytes_in = 0;
    payloads_out = 0;
    foreach (verdicts_out[i]) verdicts_out[i] = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    byte_pos = '0;
    total_len = '0;
    sum = '0;
    held_uid = '0;
    held_type = '0;
    held_size = '0;
    held_seq = '0;
  endfunction

  function void set_reg(sfdc_pkg::cfg_reg_t idx, logic [7:0] val);
    unique case (idx)
      sfdc_pkg::REG_HEADER:   header_val = val;
      sfdc_pkg::REG_USER_ID:  user_val = val;
      sfdc_pkg::REG_MSG_TYPE: msg_code = val;
      sfdc_pkg::REG_CTL_TYPE: ctl_code = val;
      default: ;
    endcase
  endfunction

  // accepted request: advance the parser and queue what it produces
  function void note_byte(logic [7:0] b);
    logic [16:0] pos;
    sfdc_pkg::result_t r;
    bytes_in++;
    pos = byte_pos;
    if (pos == 0) begin
      if (b == header_val) begin
        sum = b;
        byte_pos = 17'd1;
      end
    end else if (pos == sfdc_pkg::PosUser && b != user_val) begin
      clear_frame();
    end else begin
      sum = sum + b;
      byte_pos = pos + 17'd1;
      unique case (pos)
        sfdc_pkg::PosUser:   held_uid = b;
        sfdc_pkg::PosType:   held_type = b;
        sfdc_pkg::PosSizeLo: held_size[7:0] = b;
        sfdc_pkg::PosSizeHi: held_size[15:8] = b;
        sfdc_pkg::PosSeqLo:  held_seq[7:0] = b;
        sfdc_pkg::PosSeqHi: begin
          held_seq[15:8] = b;
          total_len = {1'b0, held_size} + 17'(sfdc_pkg::HdrLen) + 17'd1;
        end
        default: begin
          r.user_id = held_uid;
          r.ftype = held_type;
          r.size = held_size;
          r.seq = held_seq;
          if (total_len != 0 && byte_pos == total_len) begin
            r.kind = sfdc_pkg::KIND_VERDICT;
            r.data = '0;
            r.index = '0;
            r.last = 1'b1;
            if (held_type == sfdc_pkg::ResvType) r.verdict = sfdc_pkg::VERDICT_RESERVED;
            else if (sum != 0) r.verdict = sfdc_pkg::VERDICT_BAD_SUM;
            else if (held_type == msg_code) r.verdict = sfdc_pkg::VERDICT_OK_MSG;
            else if (held_type == ctl_code) r.verdict = sfdc_pkg::VERDICT_OK_CTL;
            else r.verdict = sfdc_pkg::VERDICT_UNKNOWN;
            clear_frame();
          end else begin
            r.kind = sfdc_pkg::KIND_PAYLOAD;
            r.data = b;
            r.index = 16'(pos - 17'(sfdc_pkg::HdrLen));
            r.verdict = sfdc_pkg::VERDICT_OK_MSG;
            r.last = 1'b0;
          end
          expected_q.push_back(r);
        end
      endcase
    end
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function void split(sfdc_pkg::result_t r, output logic [15:0] f[9]);
    f = '{16'(r.kind), 16'(r.data), r.index, 16'(r.user_id), 16'(r.ftype), r.size, r.seq,
          16'(r.verdict), 16'(r.last)};
  endfunction

  task check_result(sfdc_pkg::result_t got);
    sfdc_pkg::result_t want;
    logic [15:0] g[9];
    logic [15:0] w[9];
    if (expected_q.size() == 0) begin
      report($sformatf("result with nothing expected: %p", got));
    end else begin
      want = expected_q.pop_front();
      split(got, g);
      split(want, w);
      for (int i = 0; i < 9; i++) begin
        if (g[i] !== w[i])
          report($sformatf("%s got %0h want %0h", field_names[i], g[i], w[i]));
      end
      if (want.kind == sfdc_pkg::KIND_VERDICT) verdicts_out[int'(want.verdict)]++;
      else payloads_out++;
    end
  endtask
endclass

module serial_frame_deframer_checksum_tb;
  import sfdc_pkg::*;

  localparam int QuietLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_item_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_index;
  logic [7:0]  out_frame_user_id;
  logic [7:0]  out_frame_type;
  logic [15:0] out_payload_size;
  logic [15:0] out_sequence_id;
  logic [2:0]  out_verdict;
  logic        out_last_of_frame;
  logic        cfg_wr_en;
  cfg_reg_t    cfg_index;
  logic [7:0]  cfg_data;

  result_t         seen_result;
  frame_scoreboard sb;
  logic [7:0]      tx_q[$];
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              quiet_cycles = 0;

  serial_frame_deframer_checksum uut (.*);

  always #2 clk = ~clk;

  assign seen_result = {out_item_kind, out_payload_byte, out_payload_index, out_frame_user_id,
                        out_frame_type, out_payload_size, out_sequence_id, out_verdict,
                        out_last_of_frame};

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(seen_result);
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("serial_frame_deframer_checksum_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_frame(logic [7:0] ftype, logic [15:0] size, bit good_sum);
    logic [15:0] seq;
    logic [7:0]  total;
    logic [7:0]  fix;
    logic [7:0]  frame[$];
    seq = 16'($urandom);
    frame = '{sb.header_val, sb.user_val, ftype, size[7:0], size[15:8], seq[7:0], seq[15:8]};
    repeat (size) frame.push_back(8'($urandom));
    total = '0;
    foreach (frame[i]) total += frame[i];
    fix = 8'd0 - total;
    if (!good_sum) fix += 8'($urandom_range(1, 255));
    frame.push_back(fix);
    foreach (frame[i]) tx_q.push_back(frame[i]);
  endfunction

  function automatic void add_noise(int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom); while (b == sb.header_val);
      tx_q.push_back(b);
    end
  endfunction

  function automatic void add_bad_user();
    logic [7:0] b;
    tx_q.push_back(sb.header_val);
    if (sb.header_val != sb.user_val && $urandom_range(1) == 1) b = sb.header_val;
    else do b = 8'($urandom); while (b == sb.user_val);
    tx_q.push_back(b);
  endfunction

  function automatic void random_traffic(int n);
    int pick;
    int tpick;
    logic [7:0] ftype;
    logic [15:0] size;
    while (tx_q.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        tpick = $urandom_range(99);
        if (tpick < 45) ftype = sb.msg_code;
        else if (tpick < 75) ftype = sb.ctl_code;
        else if (tpick < 85) ftype = ResvType;
        else ftype = 8'($urandom);
        size = ($urandom_range(3) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(6));
        add_frame(ftype, size, $urandom_range(9) != 0);
      end else if (pick < 85) begin
        add_noise($urandom_range(1, 4));
      end else begin
        add_bad_user();
      end
    end
  endfunction

  task automatic send_queue();
    int sent = 0;
    bit holding = 0;
    while (sent < tx_q.size()) begin
      if (!holding) begin
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_rx_byte <= tx_q[sent];
          holding = 1;
        end
      end
      @(posedge clk);
      if (holding && !in_stall) begin
        sb.note_byte(tx_q[sent]);
        sent++;
        holding = 0;
      end
    end
    in_valid <= 1'b0;
    tx_q.delete();
  endtask

  task automatic settle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] h, input logic [7:0] u, input logic [7:0] m,
                          input logic [7:0] c);
    cfg_reg_t   regs[4];
    logic [7:0] vals[4];
    regs = '{REG_HEADER, REG_USER_ID, REG_MSG_TYPE, REG_CTL_TYPE};
    vals = '{h, u, m, c};
    settle();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] tail[$];
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    out_stall <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_HEADER;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: stray bytes, a wrong user id equal to the header,
    // empty payload, reserved type, then a frame left open
    tx_q = '{8'h00, 8'hff, 8'ha5, 8'ha5};
    add_frame(sb.msg_code, 16'd0, 1);
    add_frame(ResvType, 16'd1, 1);
    add_frame(8'h07, 16'd1, 1);
    tail.push_front(tx_q.pop_back());
    tail.push_front(tx_q.pop_back());
    send_queue();

    // type codes change while that frame is still open
    set_regs(8'ha5, 8'h01, 8'h07, 8'h02);
    tx_q = tail;
    random_traffic(90);
    send_queue();

    set_regs(8'h00, 8'h00, 8'h00, 8'h00);
    idle_pct = 56;
    random_traffic(80);
    send_queue();

    set_regs(8'hff, 8'hff, 8'hff, 8'hff);
    idle_pct = 0;
    stall_pct = 56;
    random_traffic(80);
    send_queue();

    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    idle_pct = 24;
    stall_pct = 24;
    random_traffic(80);
    send_queue();

    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    idle_pct = 0;
    stall_pct = 0;
    random_traffic(60);
    send_queue();

    settle();
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("sent %0d bytes, checked %0d payload items", sb.bytes_in, sb.payloads_out);
    $display("verdicts msg/ctl/sum/resv/unknown %0d/%0d/%0d/%0d/%0d",
             sb.verdicts_out[0], sb.verdicts_out[1], sb.verdicts_out[2],
             sb.verdicts_out[3], sb.verdicts_out[4]);
    $display("settings: defaults, type change inside a frame, all zero, all ones, random");
    if (sb.errors == 0) begin
      $display("serial_frame_deframer_checksum_tb OK");
    end else begin
      $display("serial_frame_deframer_checksum_tb NOT OK");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/sfdc_pkg.sv
rtl/serial_frame_deframer_checksum.sv
tb/serial_frame_deframer_checksum_tb.sv
